@@ src/cbfm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbfm_pkg
// shared types and constants of the clock buffer frame manager
// ----------------------------------------------------------------------------
package cbfm_pkg;

	localparam int NUM_FRAMES = 16;
	localparam int FW = $clog2(NUM_FRAMES);
	localparam int NW = $clog2(NUM_FRAMES + 1);

	localparam logic [2:0] FUNC_READ     = 3'd0;
	localparam logic [2:0] FUNC_UNPIN    = 3'd1;
	localparam logic [2:0] FUNC_ALLOCATE = 3'd2;
	localparam logic [2:0] FUNC_DISPOSE  = 3'd3;
	localparam logic [2:0] FUNC_FLUSH    = 3'd4;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_EXCEEDED   = 3'd1;
	localparam logic [2:0] ST_NOT_PINNED = 3'd2;
	localparam logic [2:0] ST_PINNED     = 3'd3;
	localparam logic [2:0] ST_BAD_BUFFER = 3'd4;

	typedef struct packed {
		logic          load;       // latch input word, reset index
		logic          step;       // advance scan index
		logic          hand_step;  // advance clock hand, count sweep step
		logic          clr_ref;    // clear ref bit at hand
		logic          evict;      // capture writeback at hand, clear frame
		logic          set_hand;   // set frame at hand
		logic          hit_upd;    // ref and pin at index
		logic          unpin_upd;  // pin down, dirty at index
		logic          clr_idx;    // clear frame at index
		logic          flush_out;  // capture flush writeback at index
		logic          seen_set;   // note unpinned frame seen
	} cbfm_cmd_t;

	typedef struct packed {
		logic [2:0]    func;
		logic          idx_end;    // index reached frame count
		logic          idx_match;  // frame at index matches file and page
		logic          idx_owner;  // owner at index equals file
		logic          idx_valid;
		logic          idx_pinned;
		logic          hnext_valid;
		logic          hnext_pinned;
		logic          hnext_ref;
		logic          turn_done;  // one full turn done
		logic          two_done;   // two turns done
		logic          seen;
	} cbfm_stat_t;

endpackage

@@ src/clock_buffer_frame_manager.sv @@
// ----------------------------------------------------------------------------
// clock_buffer_frame_manager
// buffer frame descriptors with clock replacement, lookup and flush
// ----------------------------------------------------------------------------
// usage: a request word enters on s_axis (func, file_id, page_no, dirty) and
// one or more result words leave on m_axis; the final one carries tlast.
// frames_in_use is written through cfg_we/cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// one request is worked at a time; s_axis_tready is high only when idle.
// lookup scans the active frames one a cycle while m_axis is free, a sweep
// steps the clock hand one frame a cycle for at most two turns, and a flush
// visits each active frame, passing through S_FOUT for each one it clears.
// reset clears all descriptors and puts the hand on the last frame.
// a stalled m_axis holds the result word; the sequencer can still take the
// next request, then waits in lookup or flush until the word is taken.
// ----------------------------------------------------------------------------
module clock_buffer_frame_manager import cbfm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [4:0]   cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,   // func, file_id, page_no, dirty, zero pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [55:0]  m_axis_tdata,   // status, frame, hit, fetch_needed,
	                                     // writeback_valid, writeback_file,
	                                     // writeback_page, zero pad
	output logic         m_axis_tlast
);

	cbfm_cmd_t  cmd;
	cbfm_stat_t stat;
	logic [FW-1:0] idx, hand;
	logic [7:0]  wbf;
	logic [31:0] wbp;
	logic wbv, o_wb, o_hit, o_fetch;
	logic [2:0] o_status;
	logic [3:0] o_frame;
	logic wv;

	cbfm_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_data,
		.in_func(s_axis_tdata[2:0]), .in_file(s_axis_tdata[10:3]),
		.in_page(s_axis_tdata[42:11]), .in_dirty(s_axis_tdata[43]),
		.cmd, .stat, .idx, .hand,
		.wb_file(wbf), .wb_page(wbp), .wb_valid(wbv)
	);

	cbfm_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.stat, .idx, .hand, .cmd,
		.o_status, .o_frame, .o_hit, .o_fetch, .o_wb, .o_last(m_axis_tlast)
	);

	assign wv = o_wb && wbv;
	assign m_axis_tdata = {6'd0, wv ? wbp : 32'd0, wv ? wbf : 8'd0, wv,
		o_fetch, o_hit, o_frame, o_status};

endmodule

@@ src/cbfm_datapath.sv @@
// ----------------------------------------------------------------------------
// cbfm_datapath
// frame descriptors, clock hand, scan index and request latch
// ----------------------------------------------------------------------------
module cbfm_datapath import cbfm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_data,
	input  logic [2:0]         in_func,
	input  logic [7:0]         in_file,
	input  logic [31:0]        in_page,
	input  logic               in_dirty,
	input  cbfm_cmd_t          cmd,
	output cbfm_stat_t         stat,
	output logic [FW-1:0]      idx,
	output logic [FW-1:0]      hand,
	output logic [7:0]         wb_file,
	output logic [31:0]        wb_page,
	output logic               wb_valid
);

	logic [4:0]            fiu_q;
	logic [NUM_FRAMES-1:0] valid_q, ref_q, dirty_q;
	logic [7:0]            owner_q [NUM_FRAMES];
	logic [31:0]           tag_q   [NUM_FRAMES];
	logic [7:0]            pin_q   [NUM_FRAMES];
	logic [FW-1:0]         hand_q, idx_q, hnext;
	logic [NW:0]           cnt_q;
	logic [NW-1:0]         idx_cnt_q;
	logic [2:0]            func_q;
	logic [7:0]            file_q;
	logic [31:0]           page_q;
	logic                  dirty_q1, seen_q;
	logic [7:0]            wbf_q;
	logic [31:0]           wbp_q;
	logic                  wbv_q;
	logic [NW-1:0]         n_eff;

	always_comb begin
		n_eff = NW'(fiu_q);
		if (fiu_q == 5'd0) n_eff = NW'(1);
		if (32'(fiu_q) > NUM_FRAMES) n_eff = NW'(NUM_FRAMES);
		if (32'(fiu_q) > 16) n_eff = NW'(16);
	end

	always_comb begin
		hnext = hand_q + FW'(1);
		if ({1'b0, NW'(hand_q)} + 1 >= {1'b0, n_eff}) hnext = '0;
	end

	assign idx = idx_q;
	assign hand = hand_q;
	assign wb_file = wbf_q;
	assign wb_page = wbp_q;
	assign wb_valid = wbv_q;

	always_comb begin
		stat.func = func_q;
		stat.idx_end = idx_cnt_q >= n_eff;
		stat.idx_valid = valid_q[idx_q];
		stat.idx_owner = owner_q[idx_q] == file_q;
		stat.idx_match = valid_q[idx_q] && owner_q[idx_q] == file_q && tag_q[idx_q] == page_q;
		stat.idx_pinned = pin_q[idx_q] != 8'd0;
		stat.hnext_valid = valid_q[hnext];
		stat.hnext_pinned = pin_q[hnext] != 8'd0;
		stat.hnext_ref = ref_q[hnext];
		stat.turn_done = cnt_q >= (NW+1)'(n_eff);
		stat.two_done = cnt_q >= ((NW+1)'(n_eff) << 1);
		stat.seen = seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= 5'd16;
			hand_q <= FW'(((NUM_FRAMES < 16) ? NUM_FRAMES : 16) - 1);
			valid_q <= '0;
			ref_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				owner_q[i] <= '0;
				pin_q[i] <= '0;
			end
			idx_q <= '0;
			idx_cnt_q <= '0;
			cnt_q <= '0;
			seen_q <= 1'b0;
			wbv_q <= 1'b0;
		end else begin
			if (cfg_we) fiu_q <= cfg_data;
			if (cmd.load) begin
				idx_q <= '0;
				idx_cnt_q <= '0;
				cnt_q <= '0;
				seen_q <= 1'b0;
			end
			if (cmd.step) begin
				idx_q <= idx_q + FW'(1);
				idx_cnt_q <= idx_cnt_q + NW'(1);
			end
			if (cmd.hand_step) begin
				hand_q <= hnext;
				cnt_q <= cnt_q + (NW+1)'(1);
				wbv_q <= 1'b0;
			end
			if (cmd.seen_set) seen_q <= 1'b1;
			if (cmd.clr_ref) ref_q[hnext] <= 1'b0;
			if (cmd.evict) begin
				wbv_q <= dirty_q[hnext];
				valid_q[hnext] <= 1'b0;
				owner_q[hnext] <= '0;
				pin_q[hnext] <= '0;
				ref_q[hnext] <= 1'b0;
				dirty_q[hnext] <= 1'b0;
			end
			if (cmd.set_hand) begin
				valid_q[hand_q] <= 1'b1;
				owner_q[hand_q] <= file_q;
				pin_q[hand_q] <= 8'd1;
				ref_q[hand_q] <= 1'b1;
				dirty_q[hand_q] <= 1'b0;
			end
			if (cmd.hit_upd) begin
				ref_q[idx_q] <= 1'b1;
				if (pin_q[idx_q] != 8'hff) pin_q[idx_q] <= pin_q[idx_q] + 8'd1;
			end
			if (cmd.unpin_upd) begin
				pin_q[idx_q] <= pin_q[idx_q] - 8'd1;
				if (dirty_q1) dirty_q[idx_q] <= 1'b1;
			end
			if (cmd.flush_out) wbv_q <= dirty_q[idx_q];
			if (cmd.clr_idx) begin
				valid_q[idx_q] <= 1'b0;
				owner_q[idx_q] <= '0;
				pin_q[idx_q] <= '0;
				ref_q[idx_q] <= 1'b0;
				dirty_q[idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			file_q <= in_file;
			page_q <= in_page;
			dirty_q1 <= in_dirty;
		end
		if (cmd.evict) begin
			wbf_q <= owner_q[hnext];
			wbp_q <= tag_q[hnext];
		end
		if (cmd.flush_out) begin
			wbf_q <= owner_q[idx_q];
			wbp_q <= tag_q[idx_q];
		end
		if (cmd.set_hand) tag_q[hand_q] <= page_q;
		if (cmd.clr_idx) tag_q[idx_q] <= '0;
	end

endmodule

@@ src/cbfm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbfm_ctrl
// sequencer for lookup, clock sweep and flush scan, with output register
// ----------------------------------------------------------------------------
module cbfm_ctrl import cbfm_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  cbfm_stat_t     stat,
	input  logic [FW-1:0]  idx,
	input  logic [FW-1:0]  hand,
	output cbfm_cmd_t      cmd,
	output logic [2:0]     o_status,
	output logic [3:0]     o_frame,
	output logic           o_hit,
	output logic           o_fetch,
	output logic           o_wb,
	output logic           o_last
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOOK  = 7'b0000010,
		S_SWEEP = 7'b0000100,
		S_SET   = 7'b0001000,
		S_FLUSH = 7'b0010000,
		S_FOUT  = 7'b0100000,
		S_WAIT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   ov_q, ov_d, wbsel_q, wbsel_d;
	logic [2:0] st_q, st_d;
	logic [3:0] fr_q, fr_d;
	logic hit_q, hit_d, fe_q, fe_d, last_q, last_d;

	wire out_free = !ov_q || out_ready;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = ov_q;
	assign o_status = st_q;
	assign o_frame = fr_q;
	assign o_hit = hit_q;
	assign o_fetch = fe_q;
	assign o_wb = wbsel_q;
	assign o_last = last_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		ov_d = ov_q && !out_ready;
		wbsel_d = wbsel_q;
		st_d = st_q; fr_d = fr_q; hit_d = hit_q; fe_d = fe_q; last_d = last_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (out_free) begin
					st_d = ST_OK; fr_d = '0; hit_d = 1'b0; fe_d = 1'b0;
					wbsel_d = 1'b0; last_d = 1'b1;
					if (stat.func == FUNC_ALLOCATE) begin
						state_d = S_SWEEP;
					end else if (stat.func == FUNC_FLUSH) begin
						state_d = S_FLUSH;
					end else if (!(stat.func == FUNC_READ || stat.func == FUNC_UNPIN ||
							stat.func == FUNC_DISPOSE)) begin
						ov_d = 1'b1; state_d = S_IDLE;
					end else if (stat.idx_end) begin
						if (stat.func == FUNC_READ) state_d = S_SWEEP;
						else begin
							ov_d = 1'b1; state_d = S_IDLE;
						end
					end else if (stat.idx_match) begin
						fr_d = 4'(idx);
						if (stat.func == FUNC_READ) begin
							cmd.hit_upd = 1'b1; hit_d = 1'b1;
						end else if (stat.func == FUNC_UNPIN) begin
							if (stat.idx_pinned) cmd.unpin_upd = 1'b1;
							else st_d = ST_NOT_PINNED;
						end else begin
							cmd.clr_idx = 1'b1;
						end
						ov_d = 1'b1; state_d = S_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			S_SWEEP: begin
				if (stat.two_done || (stat.turn_done && !stat.seen)) begin
					st_d = ST_EXCEEDED; ov_d = 1'b1; state_d = S_IDLE;
				end else begin
					cmd.hand_step = 1'b1;
					if (!stat.hnext_valid) state_d = S_SET;
					else if (!stat.hnext_pinned) begin
						cmd.seen_set = 1'b1;
						if (stat.hnext_ref) cmd.clr_ref = 1'b1;
						else begin
							cmd.evict = 1'b1; state_d = S_SET;
						end
					end
				end
			end
			S_SET: begin
				cmd.set_hand = 1'b1;
				fr_d = 4'(hand);
				fe_d = stat.func == FUNC_READ;
				wbsel_d = 1'b1;
				ov_d = 1'b1; state_d = S_IDLE;
			end
			S_FLUSH: begin
				if (out_free) begin
					wbsel_d = 1'b0; hit_d = 1'b0; fe_d = 1'b0;
					if (stat.idx_end) begin
						st_d = ST_OK; fr_d = '0; last_d = 1'b1;
						ov_d = 1'b1; state_d = S_IDLE;
					end else if (!stat.idx_owner) begin
						cmd.step = 1'b1;
					end else if (!stat.idx_valid) begin
						st_d = ST_BAD_BUFFER; fr_d = 4'(idx); last_d = 1'b1;
						ov_d = 1'b1; state_d = S_IDLE;
					end else if (stat.idx_pinned) begin
						st_d = ST_PINNED; fr_d = 4'(idx); last_d = 1'b1;
						ov_d = 1'b1; state_d = S_IDLE;
					end else begin
						st_d = ST_OK; fr_d = 4'(idx); last_d = 1'b0;
						wbsel_d = 1'b1;
						cmd.flush_out = 1'b1; cmd.clr_idx = 1'b1; cmd.step = 1'b1;
						ov_d = 1'b1; state_d = S_FOUT;
					end
				end
			end
			S_FOUT: state_d = S_FLUSH;
			S_WAIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		st_q <= st_d; fr_q <= fr_d; hit_q <= hit_d; fe_q <= fe_d;
		last_q <= last_d; wbsel_q <= wbsel_d;
	end

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> ov_q) else $error("result dropped");
	a_evict_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |=> state_q == S_SET) else $error("evict without set");
`endif

endmodule

@@ tb/clock_buffer_frame_manager_checker.sv @@
// ----------------------------------------------------------------------------
// clock_buffer_frame_manager_checker
// watches the request and result streams, keeps its own copy of the frame
// descriptors and clock hand, predicts each result word and compares them
// ----------------------------------------------------------------------------
module clock_buffer_frame_manager_checker import cbfm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [4:0]   cfg_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [55:0]  m_axis_tdata,
	input  logic         m_axis_tlast,
	output int           fail_count,
	output int           pending,
	output int           results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  frame;
		logic        hit;
		logic        fetch;
		logic        wb_valid;
		logic [7:0]  wb_file;
		logic [31:0] wb_page;
		logic        last;
	} result_t;

	result_t result_q[$];

	logic [4:0]  frames_reg;
	logic        f_valid [NUM_FRAMES];
	logic [7:0]  f_owner [NUM_FRAMES];
	logic [31:0] f_tag   [NUM_FRAMES];
	logic [7:0]  f_pin   [NUM_FRAMES];
	logic        f_ref   [NUM_FRAMES];
	logic        f_dirty [NUM_FRAMES];
	int          hand;

	function automatic int active_frames();
		int n;
		n = frames_reg;
		if (n < 1) n = 1;
		if (n > NUM_FRAMES) n = NUM_FRAMES;
		return n;
	endfunction

	function automatic void wipe(int f);
		f_valid[f] = 0;
		f_owner[f] = 0;
		f_tag[f] = 0;
		f_pin[f] = 0;
		f_ref[f] = 0;
		f_dirty[f] = 0;
	endfunction

	function automatic void install(int f, logic [7:0] file, logic [31:0] page);
		f_valid[f] = 1;
		f_owner[f] = file;
		f_tag[f] = page;
		f_pin[f] = 1;
		f_ref[f] = 1;
		f_dirty[f] = 0;
	endfunction

	function automatic int find_page(int n, logic [7:0] file, logic [31:0] page);
		for (int i = 0; i < n; i++)
			if (f_valid[i] && f_owner[i] == file && f_tag[i] == page)
				return i;
		return -1;
	endfunction

	// returns victim frame or -1, fills writeback fields of r
	function automatic int clock_sweep(int n, inout result_t r);
		bit seen_free;
		int h;
		seen_free = 0;
		for (int i = 0; i < 2 * n; i++) begin
			if (i >= n && !seen_free) break;
			h = hand + 1;
			if (h >= n) h = 0;
			hand = h;
			if (!f_valid[h]) return h;
			if (f_pin[h] != 0) continue;
			seen_free = 1;
			if (f_ref[h]) begin
				f_ref[h] = 0;
				continue;
			end
			if (f_dirty[h]) begin
				r.wb_valid = 1;
				r.wb_file = f_owner[h];
				r.wb_page = f_tag[h];
			end
			wipe(h);
			return h;
		end
		return -1;
	endfunction

	function automatic void predict_request(logic [47:0] word);
		logic [2:0]  func;
		logic [7:0]  file;
		logic [31:0] page;
		logic        dirty;
		int          n;
		int          f;
		result_t     r;
		func = word[2:0];
		file = word[10:3];
		page = word[42:11];
		dirty = word[43];
		n = active_frames();
		r = '0;
		r.last = 1;
		case (func)
			FUNC_READ: begin
				f = find_page(n, file, page);
				if (f >= 0) begin
					f_ref[f] = 1;
					if (f_pin[f] != 8'd255) f_pin[f]++;
					r.frame = 4'(f);
					r.hit = 1;
				end else begin
					f = clock_sweep(n, r);
					if (f >= 0) begin
						install(f, file, page);
						r.frame = 4'(f);
						r.fetch = 1;
					end else r.status = ST_EXCEEDED;
				end
				result_q.push_back(r);
			end
			FUNC_UNPIN: begin
				f = find_page(n, file, page);
				if (f >= 0) begin
					r.frame = 4'(f);
					if (f_pin[f] == 0) r.status = ST_NOT_PINNED;
					else begin
						f_pin[f]--;
						if (dirty) f_dirty[f] = 1;
					end
				end
				result_q.push_back(r);
			end
			FUNC_ALLOCATE: begin
				f = clock_sweep(n, r);
				if (f >= 0) begin
					install(f, file, page);
					r.frame = 4'(f);
				end else r.status = ST_EXCEEDED;
				result_q.push_back(r);
			end
			FUNC_DISPOSE: begin
				f = find_page(n, file, page);
				if (f >= 0) begin
					wipe(f);
					r.frame = 4'(f);
				end
				result_q.push_back(r);
			end
			FUNC_FLUSH: begin
				for (int i = 0; i < n; i++) begin
					if (f_owner[i] != file) continue;
					r = '0;
					r.frame = 4'(i);
					if (!f_valid[i] || f_pin[i] != 0) begin
						r.status = f_valid[i] ? ST_PINNED : ST_BAD_BUFFER;
						r.last = 1;
						result_q.push_back(r);
						return;
					end
					if (f_dirty[i]) begin
						r.wb_valid = 1;
						r.wb_file = f_owner[i];
						r.wb_page = f_tag[i];
					end
					result_q.push_back(r);
					wipe(i);
				end
				r = '0;
				r.last = 1;
				result_q.push_back(r);
			end
			default: result_q.push_back(r);
		endcase
	endfunction

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			frames_reg <= 5'd16;
			for (int i = 0; i < NUM_FRAMES; i++) wipe(i);
			hand = NUM_FRAMES - 1;
			result_q.delete();
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				got.status = m_axis_tdata[2:0];
				got.frame = m_axis_tdata[6:3];
				got.hit = m_axis_tdata[7];
				got.fetch = m_axis_tdata[8];
				got.wb_valid = m_axis_tdata[9];
				got.wb_file = m_axis_tdata[17:10];
				got.wb_page = m_axis_tdata[49:18];
				got.last = m_axis_tlast;
				if (result_q.size() == 0) begin
					$display("%0t unexpected result word %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						$display("%0t mismatch: expected st=%0d fr=%0d hit=%0d fe=%0d wb=%0d/%0d/%h last=%0d",
							$time, want.status, want.frame, want.hit, want.fetch,
							want.wb_valid, want.wb_file, want.wb_page, want.last);
						$display("%0t           actual   st=%0d fr=%0d hit=%0d fe=%0d wb=%0d/%0d/%h last=%0d",
							$time, got.status, got.frame, got.hit, got.fetch,
							got.wb_valid, got.wb_file, got.wb_page, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tdata);
			if (cfg_we) begin
				frames_reg <= cfg_data;
				// a new frame count does not move the hand; wrap handles it
			end
		end
	end
endmodule

@@ tb/clock_buffer_frame_manager_tb.sv @@
// ----------------------------------------------------------------------------
// clock_buffer_frame_manager_tb
// drives directed and random page requests through several frame counts,
// with random gaps and stalls on both streams; the checker judges results
// ----------------------------------------------------------------------------
module clock_buffer_frame_manager_tb import cbfm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_count;
	int          pending;
	int          results_seen;
	int          words_sent;
	bit          hold_off;
	bit          long_hold;

	clock_buffer_frame_manager dut (.*);

	clock_buffer_frame_manager_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: random stalls, plus one long hold when asked
	initial begin
		int g;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
				long_hold = 0;
			end
			g = hold_off ? 0 : gap_len();
			if (g > 0) begin
				m_axis_tready <= 0;
				repeat (g) @(posedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
		end
	end

	task automatic send(logic [2:0] func, logic [7:0] file, logic [31:0] page, logic dirty);
		int g;
		g = hold_off ? 0 : gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {4'd0, dirty, page, file, func};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_frames(logic [4:0] v);
		drain();
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// random phase: mostly a small working set so hits, pins and flushes bite
	task automatic random_phase(int count);
		logic [2:0]  func;
		logic [7:0]  file;
		logic [31:0] page;
		int p;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(0, 99);
			func = p < 35 ? FUNC_READ : p < 65 ? FUNC_UNPIN : p < 78 ? FUNC_ALLOCATE :
				p < 88 ? FUNC_DISPOSE : p < 97 ? FUNC_FLUSH : 3'($urandom_range(5, 7));
			if ($urandom_range(0, 9) < 8) begin
				file = 8'($urandom_range(1, 3));
				page = $urandom_range(0, 5);
			end else begin
				file = 8'($urandom_range(1, 255));
				page = $urandom();
			end
			send(func, file, page, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		hold_off = 0;
		long_hold = 0;
		words_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes and special cases at full frame count
		send(FUNC_FLUSH, 8'd1, 0, 0);
		send(FUNC_UNPIN, 8'd9, 32'd5, 0);
		send(FUNC_DISPOSE, 8'd9, 32'd5, 0);
		send(FUNC_READ, 8'd255, 32'hFFFF_FFFF, 0);
		send(FUNC_READ, 8'd255, 32'hFFFF_FFFF, 0);
		send(FUNC_UNPIN, 8'd255, 32'hFFFF_FFFF, 1);
		send(FUNC_UNPIN, 8'd255, 32'hFFFF_FFFF, 1);
		send(FUNC_UNPIN, 8'd255, 32'hFFFF_FFFF, 0);
		send(FUNC_ALLOCATE, 8'd1, 32'd0, 0);
		send(FUNC_ALLOCATE, 8'd1, 32'd0, 0);
		send(FUNC_UNPIN, 8'd1, 32'd0, 1);
		send(FUNC_FLUSH, 8'd1, 0, 0);
		send(FUNC_FLUSH, 8'd255, 0, 0);
		send(3'd7, 8'd0, 32'hFFFF_FFFF, 1);
		send(3'd5, 8'd128, 32'h8000_0000, 0);
		send(FUNC_DISPOSE, 8'd1, 32'd0, 0);

		// tiny frame count: fill, exceed, evict dirty pages
		set_frames(5'd1);
		send(FUNC_READ, 8'd2, 32'd1, 0);
		send(FUNC_READ, 8'd2, 32'd2, 0);
		send(FUNC_ALLOCATE, 8'd2, 32'd3, 0);
		send(FUNC_UNPIN, 8'd2, 32'd1, 1);
		send(FUNC_READ, 8'd2, 32'd2, 0);
		send(FUNC_READ, 8'd2, 32'd2, 0);
		send(FUNC_FLUSH, 8'd2, 0, 0);
		send(FUNC_READ, 8'd2, 32'd2, 0);

		set_frames(5'd0);
		random_phase(40);
		set_frames(5'd2);
		random_phase(50);
		set_frames(5'd4);
		random_phase(60);

		// sender waits until every result is in
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		set_frames(5'd31);
		long_hold = 1;
		random_phase(40);
		set_frames(5'd16);
		hold_off = 1;
		random_phase(40);
		hold_off = 0;
		random_phase(60);
		set_frames(5'd7);
		random_phase(60);

		drain();
		$display("covered %0d requests and %0d result words over frame counts 0..31",
			words_sent, results_seen);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
